// ===== design/ftc_pkg.sv =====
// Shared types, constants and calendar tables of the FAT timestamp to tick count unit.
package ftc_pkg;

  localparam int unsigned YEAR_W      = 7;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned MINUTE_W    = 6;
  localparam int unsigned DSEC_W      = 5;
  localparam int unsigned HUND_W      = 8;
  localparam int unsigned TICKS_W     = 58;

  localparam int unsigned DAYS_W      = 18;
  localparam int unsigned SOD_W       = 17;
  localparam int unsigned MS_W        = 10;
  localparam int unsigned SECS_W      = 34;
  localparam int unsigned SECS_LO_W   = 17;
  localparam int unsigned SECS_HI_W   = SECS_W - SECS_LO_W;
  localparam int unsigned TPS_W       = 24;
  localparam int unsigned PART_W      = SECS_LO_W + TPS_W;
  localparam int unsigned MSC_W       = 24;

  localparam int unsigned DAYS_TO_1980  = 138426;
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned TICKS_PER_SEC = 10000000;
  localparam int unsigned TICKS_PER_MS  = 10000;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned YEAR_2100_OFS = 120;

  typedef struct packed {
    logic                ok;
    logic [DAYS_W-1:0]   days;
    logic [SOD_W-1:0]    sod;
    logic [MS_W-1:0]     ms;
  } dec_t;

  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] l;
    case (month)
      4'd2:    l = 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ===== design/ftc_decode.sv =====
// First pipeline stage: field checks, day count, second of day and milliseconds.
module ftc_decode (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ftc_pkg::YEAR_W-1:0]    year_offset_i,
  input  logic [ftc_pkg::MONTH_W-1:0]   month_i,
  input  logic [ftc_pkg::DAY_W-1:0]     day_i,
  input  logic [ftc_pkg::HOUR_W-1:0]    hour_i,
  input  logic [ftc_pkg::MINUTE_W-1:0]  minute_i,
  input  logic [ftc_pkg::DSEC_W-1:0]    double_seconds_i,
  input  logic [ftc_pkg::HUND_W-1:0]    hundredths_i,
  output ftc_pkg::dec_t                 dec_o
);
  import ftc_pkg::*;

  logic             leap;
  logic [5:0]       leap_cnt;
  logic [1:0]       fine_q;
  logic [6:0]       fine_r;
  logic [6:0]       sec;
  logic [5:0]       sec_fix;
  logic [DAY_W:0]   len;
  logic             ok;
  logic [DAYS_W-1:0] days;
  logic [SOD_W-1:0]  sod;
  logic [MS_W-1:0]   ms;
  dec_t             dec_d;
  dec_t             dec_q;

  always_comb begin
    leap = (year_offset_i[1:0] == 2'd0) && (year_offset_i != YEAR_W'(YEAR_2100_OFS));
    leap_cnt = 6'((({1'b0, year_offset_i} + 8'd3) >> 2)
               - ((year_offset_i > YEAR_W'(YEAR_2100_OFS)) ? 8'd1 : 8'd0));

    if (hundredths_i >= 8'd200) begin
      fine_q = 2'd2;
      fine_r = 7'(hundredths_i - 8'd200);
    end else if (hundredths_i >= 8'd100) begin
      fine_q = 2'd1;
      fine_r = 7'(hundredths_i - 8'd100);
    end else begin
      fine_q = 2'd0;
      fine_r = hundredths_i[6:0];
    end
    sec = {1'b0, double_seconds_i, 1'b0} + 7'(fine_q);
    sec_fix = (sec > 7'd59) ? 6'd0 : sec[5:0];

    len = {1'b0, month_len(month_i)} + ((leap && month_i == 4'd2) ? 6'd1 : 6'd0);
    ok = (minute_i <= 6'd59) && (hour_i <= 5'd23) && (month_i >= 4'd1)
         && (month_i <= 4'd12) && (day_i >= 5'd1) && ({1'b0, day_i} <= len);

    days = DAYS_W'(DAYS_TO_1980) + DAYS_W'(year_offset_i) * DAYS_W'(DAYS_PER_YEAR)
           + DAYS_W'(leap_cnt) + DAYS_W'(cum_days(month_i))
           + ((leap && month_i > 4'd2) ? DAYS_W'(1) : DAYS_W'(0))
           + DAYS_W'(day_i) - DAYS_W'(1);
    sod = SOD_W'(hour_i) * SOD_W'(3600) + SOD_W'(minute_i) * SOD_W'(60) + SOD_W'(sec_fix);
    ms = MS_W'(fine_r) * MS_W'(10);

    dec_d.ok   = ok;
    dec_d.days = ok ? days : '0;
    dec_d.sod  = ok ? sod : '0;
    dec_d.ms   = ok ? ms : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

// ===== design/ftc_scale.sv =====
// Pipeline stages two to five: scaling of days and seconds into 100 ns ticks.
module ftc_scale (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  ftc_pkg::dec_t                dec_i,
  output logic [ftc_pkg::TICKS_W-1:0]  ticks_o,
  output logic                         ok_o
);
  import ftc_pkg::*;

  logic [DAYS_W+SOD_W-1:0] prod;
  logic [SECS_W-1:0]       prod_q;
  logic [SOD_W-1:0]        sod_q;
  logic [MS_W-1:0]         ms2_q;
  logic                    ok2_q;

  logic [SECS_W-1:0]       secs_d;
  logic [SECS_W-1:0]       secs_q;
  logic [MS_W-1:0]         ms3_q;
  logic                    ok3_q;

  logic [PART_W-1:0]       ph_d;
  logic [PART_W-1:0]       pl_d;
  logic [MSC_W-1:0]        msc_d;
  logic [PART_W-1:0]       ph_q;
  logic [PART_W-1:0]       pl_q;
  logic [MSC_W-1:0]        msc_q;
  logic                    ok4_q;

  logic [TICKS_W-1:0]      ticks_d;
  logic [TICKS_W-1:0]      ticks_q;
  logic                    ok5_q;

  always_comb begin
    prod    = (DAYS_W+SOD_W)'(dec_i.days) * (DAYS_W+SOD_W)'(SEC_PER_DAY);
    secs_d  = prod_q + SECS_W'(sod_q);
    ph_d    = PART_W'(secs_q[SECS_W-1:SECS_LO_W]) * PART_W'(TICKS_PER_SEC);
    pl_d    = PART_W'(secs_q[SECS_LO_W-1:0]) * PART_W'(TICKS_PER_SEC);
    msc_d   = MSC_W'(ms3_q) * MSC_W'(TICKS_PER_MS);
    ticks_d = {ph_q[TICKS_W-SECS_LO_W-1:0], {SECS_LO_W{1'b0}}}
              + TICKS_W'(pl_q) + TICKS_W'(msc_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod[SECS_W-1:0];
      sod_q   <= dec_i.sod;
      ms2_q   <= dec_i.ms;
      ok2_q   <= dec_i.ok;
      secs_q  <= secs_d;
      ms3_q   <= ms2_q;
      ok3_q   <= ok2_q;
      ph_q    <= ph_d;
      pl_q    <= pl_d;
      msc_q   <= msc_d;
      ok4_q   <= ok3_q;
      ticks_q <= ticks_d;
      ok5_q   <= ok4_q;
    end
  end

  assign ticks_o = ticks_q;
  assign ok_o    = ok5_q;

endmodule

// ===== design/fat_datetime_to_tick_count_unit.sv =====
// Top level of the FAT timestamp to 100 ns tick count conversion pipeline.
//
// The input channel takes one FAT date and time per transaction, with the
// fine count in 10 ms units, and the output channel returns the number of
// 100 ns ticks since 1601-01-01 and a flag that is set when month, day,
// hour and minute are in range; else ticks are zero and the flag is clear.
// A transaction moves when valid is high and stall is low.
// The pipeline has five register stages: field decode and day count, the
// day-to-second multiply, the second-of-day add, two partial multiplies by
// the ticks per second, and the final sum. One transaction is accepted in
// every cycle unless the output stalls; the constant multipliers set the
// stage split. Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver stalls a valid result, the whole pipeline holds and the
// input stall is raised in the same cycle; bubbles do not move while the
// output is held. Nothing is lost or repeated across a stall.
module fat_datetime_to_tick_count_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ftc_pkg::YEAR_W-1:0]    year_offset_i,
  input  logic [ftc_pkg::MONTH_W-1:0]   month_i,
  input  logic [ftc_pkg::DAY_W-1:0]     day_i,
  input  logic [ftc_pkg::HOUR_W-1:0]    hour_i,
  input  logic [ftc_pkg::MINUTE_W-1:0]  minute_i,
  input  logic [ftc_pkg::DSEC_W-1:0]    double_seconds_i,
  input  logic [ftc_pkg::HUND_W-1:0]    hundredths_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ftc_pkg::TICKS_W-1:0]   ticks_o,
  output logic                          valid_res_o
);
  import ftc_pkg::*;

  localparam int unsigned NumStages = 5;

  logic                 adv;
  logic [NumStages-1:0] v_d;
  logic [NumStages-1:0] v_q;
  dec_t                 dec;

  assign adv        = !(v_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign v_d        = {v_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  ftc_decode u_decode (
    .clk_i            (clk_i),
    .en_i             (adv),
    .year_offset_i    (year_offset_i),
    .month_i          (month_i),
    .day_i            (day_i),
    .hour_i           (hour_i),
    .minute_i         (minute_i),
    .double_seconds_i (double_seconds_i),
    .hundredths_i     (hundredths_i),
    .dec_o            (dec)
  );

  ftc_scale u_scale (
    .clk_i   (clk_i),
    .en_i    (adv),
    .dec_i   (dec),
    .ticks_o (ticks_o),
    .ok_o    (valid_res_o)
  );

  assign out_valid_o = v_q[NumStages-1];

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> ticks_o == '0)
    else $error("invalid result carries nonzero ticks");

  a_valid_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> v_q[NumStages-1] == $past(v_q[NumStages-2]))
    else $error("valid bit lost between last two stages");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(v_q))
    else $error("pipeline moved while output stalled");

endmodule
